### rtl/core/pts_pkg.sv
package pts_pkg;

    // Request codes carried on the input tuser.
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_DEL   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Result kinds carried on the output tuser.
    localparam logic [2:0] KIND_ADD   = 3'd0;
    localparam logic [2:0] KIND_DEL   = 3'd1;
    localparam logic [2:0] KIND_CLEAR = 3'd2;
    localparam logic [2:0] KIND_FIRE  = 3'd3;
    localparam logic [2:0] KIND_FULL  = 3'd4;

    // Most firings one tick may produce.
    localparam int          MAX_FIRE  = 16;
    localparam logic [4:0]  FIRE_LIM  = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic scan_last;
        logic out_busy;
        logic again;
    } t_status;

endpackage

### rtl/core/periodic_timer_scheduler.sv
// Periodic timer table with a millisecond tick.
// Input stream: tuser carries the request (add, delete, clear, tick) and
// tdata carries task id, delay and interval. Output stream: tuser carries the
// result kind, tdata the id, and tlast marks the final word of a request.
// Add, delete and clear each answer with one word; a tick answers with one
// word per fired timer in due-time order, or with nothing.
// A request is taken, then, except for a clear, the slot table is walked
// one slot per cycle. Add and delete walk it once before their result word
// is written; a clear writes its word without a walk. A tick walks it once
// per fired timer plus one final walk.
// One request is in progress at a time; the input is ready only between
// requests, while the last result word may still sit in the output register.
// When the receiver stalls, the walk pauses before each new result word.
// Reset empties the table and clears the tick and id counters; the block is
// ready in the first cycle after reset.
module periodic_timer_scheduler
    import pts_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // task_id, delay, interval
    input  logic [1:0]  i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // result_id
    output logic [2:0]  o_m_tuser,   // kind
    output logic        o_m_tlast
);

    t_cmd    cmd;
    t_status status;

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    pts_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_s_tuser),
        .i_tid       (i_s_tdata[31:0]),
        .i_dly       (i_s_tdata[63:32]),
        .i_ivl       (i_s_tdata[95:64]),
        .i_out_ready (i_m_tready),
        .o_status    (status),
        .o_out_valid (o_m_tvalid),
        .o_out_kind  (o_m_tuser),
        .o_out_id    (o_m_tdata),
        .o_out_last  (o_m_tlast)
    );

`ifndef SYNTH
    // Only one request is taken at a time.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in progress");

    // Only firings can be followed by more words.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != KIND_FIRE) |-> o_m_tlast)
        else $error("non-fire result without last");
`endif

endmodule

### rtl/core/pts_ctrl.sv
module pts_ctrl
    import pts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.is_clear) begin
                    n_state = ST_APPLY;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_status.scan_last) begin
                        n_state = ST_APPLY;
                    end
                end
            end
            ST_APPLY: begin
                if (!i_status.out_busy) begin
                    o_cmd.apply = 1'b1;
                    n_state     = i_status.again ? ST_SCAN : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/pts_dp.sv
module pts_dp
    import pts_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_req,
    input  logic [31:0] i_tid,
    input  logic [31:0] i_dly,
    input  logic [31:0] i_ivl,
    input  logic        i_out_ready,
    output t_status     o_status,
    output logic        o_out_valid,
    output logic [2:0]  o_out_kind,
    output logic [31:0] o_out_id,
    output logic        o_out_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    // Slot table.
    logic [SLOTS-1:0]     r_valid;
    logic [SLOTS-1:0]     r_fired;
    logic [31:0]          r_id  [SLOTS];
    logic [TIME_BITS-1:0] r_due [SLOTS];
    logic [31:0]          r_ivl [SLOTS];

    // Request context.
    logic [1:0]           r_req;
    logic [31:0]          r_tid;
    logic [31:0]          r_dly;
    logic [31:0]          r_ivl_in;
    logic [31:0]          r_eid;
    logic [31:0]          r_idc;
    logic [TIME_BITS-1:0] r_now;

    // Scan state.
    logic [IDX_W-1:0]     r_idx;
    logic                 r_hit_ok;
    logic [IDX_W-1:0]     r_hit_idx;
    logic                 r_free_ok;
    logic [IDX_W-1:0]     r_free_idx;
    logic                 r_best_ok;
    logic [IDX_W-1:0]     r_best_idx;
    logic [TIME_BITS-1:0] r_best_due;
    logic [31:0]          r_best_ivl;
    logic [31:0]          r_best_id;
    logic [4:0]           r_cnt;
    logic                 r_pend;
    logic [31:0]          r_pend_id;

    // Output register.
    logic                 r_out_valid;
    logic [2:0]           r_out_kind;
    logic [31:0]          r_out_id;
    logic                 r_out_last;

    logic [31:0]          n_idc;
    logic                 cur_valid;
    logic [31:0]          cur_id;
    logic [TIME_BITS-1:0] cur_due;
    logic                 cand;
    logic                 found;
    logic [IDX_W-1:0]     wr_idx;

    assign n_idc     = r_idc + 32'd1;
    assign cur_valid = r_valid[r_idx];
    assign cur_id    = r_id[r_idx];
    assign cur_due   = r_due[r_idx];
    assign cand      = cur_valid && !r_fired[r_idx] && (cur_due <= r_now)
                       && (!r_best_ok || (cur_due < r_best_due));
    assign found     = r_best_ok && (r_cnt < FIRE_LIM);
    assign wr_idx    = r_hit_ok ? r_hit_idx : r_free_idx;

    assign o_status.is_clear  = (r_req == REQ_CLEAR);
    assign o_status.scan_last = (r_idx == IDX_LAST);
    assign o_status.out_busy  = r_out_valid;
    assign o_status.again     = (r_req == REQ_TICK) && found;

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_id    = r_out_id;
    assign o_out_last  = r_out_last;

    // Control state: counters, valid bits, scan flags, output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fired     <= '0;
            r_idc       <= '0;
            r_now       <= '0;
            r_idx       <= '0;
            r_hit_ok    <= 1'b0;
            r_free_ok   <= 1'b0;
            r_best_ok   <= 1'b0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_req       <= REQ_ADD;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_req     <= i_req;
                r_idx     <= '0;
                r_hit_ok  <= 1'b0;
                r_free_ok <= 1'b0;
                r_best_ok <= 1'b0;
                r_fired   <= '0;
                r_cnt     <= '0;
                r_pend    <= 1'b0;
                if (i_req == REQ_ADD) begin
                    r_idc <= n_idc;
                end
                if (i_req == REQ_TICK) begin
                    r_now <= r_now + TIME_BITS'(1);
                end
            end
            if (i_cmd.scan) begin
                r_idx <= r_idx + IDX_W'(1);
                if (cur_valid && (cur_id == r_eid) && !r_hit_ok) begin
                    r_hit_ok <= 1'b1;
                end
                if (!cur_valid && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                end
                if ((r_req == REQ_DEL) && cur_valid && (cur_id == r_tid)) begin
                    r_valid[r_idx] <= 1'b0;
                end
                if ((r_req == REQ_TICK) && cand) begin
                    r_best_ok <= 1'b1;
                end
            end
            if (i_cmd.apply) begin
                r_idx     <= '0;
                r_best_ok <= 1'b0;
                case (r_req)
                    REQ_ADD: begin
                        r_out_valid <= 1'b1;
                        if (r_hit_ok || r_free_ok) begin
                            r_valid[wr_idx] <= 1'b1;
                        end
                    end
                    REQ_DEL: begin
                        r_out_valid <= 1'b1;
                    end
                    REQ_CLEAR: begin
                        r_valid     <= '0;
                        r_out_valid <= 1'b1;
                    end
                    default: begin
                        if (found) begin
                            r_fired[r_best_idx] <= 1'b1;
                            r_cnt               <= r_cnt + 5'd1;
                            r_pend              <= 1'b1;
                            r_out_valid         <= r_pend;
                        end else begin
                            r_pend      <= 1'b0;
                            r_out_valid <= r_pend;
                        end
                    end
                endcase
            end
        end
    end

    // Payload: table contents, captured scan data and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tid    <= i_tid;
            r_dly    <= i_dly;
            r_ivl_in <= i_ivl;
            r_eid    <= (i_tid == 32'd0) ? n_idc : i_tid;
        end
        if (i_cmd.scan) begin
            if (cur_valid && (cur_id == r_eid) && !r_hit_ok) begin
                r_hit_idx <= r_idx;
            end
            if (!cur_valid && !r_free_ok) begin
                r_free_idx <= r_idx;
            end
            if (cand) begin
                r_best_idx <= r_idx;
                r_best_due <= cur_due;
                r_best_ivl <= r_ivl[r_idx];
                r_best_id  <= cur_id;
            end
        end
        if (i_cmd.apply) begin
            case (r_req)
                REQ_ADD: begin
                    r_out_id   <= r_idc;
                    r_out_last <= 1'b1;
                    if (r_hit_ok || r_free_ok) begin
                        r_out_kind     <= KIND_ADD;
                        r_id[wr_idx]   <= r_eid;
                        r_due[wr_idx]  <= r_now + TIME_BITS'(r_dly);
                        r_ivl[wr_idx]  <= r_ivl_in;
                    end else begin
                        r_out_kind <= KIND_FULL;
                    end
                end
                REQ_DEL: begin
                    r_out_kind <= KIND_DEL;
                    r_out_id   <= r_tid;
                    r_out_last <= 1'b1;
                end
                REQ_CLEAR: begin
                    r_out_kind <= KIND_CLEAR;
                    r_out_id   <= 32'd0;
                    r_out_last <= 1'b1;
                end
                default: begin
                    r_out_kind <= KIND_FIRE;
                    r_out_id   <= r_pend_id;
                    r_out_last <= !found;
                    if (found) begin
                        r_pend_id         <= r_best_id;
                        r_due[r_best_idx] <= r_best_due + TIME_BITS'(r_best_ivl);
                    end
                end
            endcase
        end
    end

endmodule
